FILE: rtl/core/tle_pkg.sv
// Shared types and constants for the terminal line editor.
package tle_pkg;

    // Classified action for one received byte
    typedef logic [1:0] act_t;
    localparam act_t ACT_NONE = 2'd0;
    localparam act_t ACT_CR   = 2'd1;
    localparam act_t ACT_BS   = 2'd2;
    localparam act_t ACT_CHAR = 2'd3;

    // Parser modes
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_PLAIN = 2'd0;
    localparam mode_t MODE_ESC   = 2'd1;
    localparam mode_t MODE_CSI   = 2'd2;

    // Result word kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ECHO = 2'd0;
    localparam kind_t KIND_CMD  = 2'd1;
    localparam kind_t KIND_END  = 2'd2;

    // Output byte select
    typedef logic [2:0] sel_t;
    localparam sel_t SEL_PROMPT = 3'd0;
    localparam sel_t SEL_LF     = 3'd1;
    localparam sel_t SEL_CMD    = 3'd2;
    localparam sel_t SEL_END    = 3'd3;
    localparam sel_t SEL_BS     = 3'd4;
    localparam sel_t SEL_SP     = 3'd5;
    localparam sel_t SEL_CHAR   = 3'd6;

    // Character codes
    localparam logic [7:0] CH_BS     = 8'd8;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_ESC    = 8'd27;
    localparam logic [7:0] CH_SP     = 8'd32;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_PROMPT = 8'd62;  // '>'
    localparam logic [7:0] CH_LBRK   = 8'd91;  // '['
    localparam logic [7:0] CH_UA     = 8'd65;  // 'A'
    localparam logic [7:0] CH_LZ     = 8'd122; // 'z'
    localparam logic [7:0] CH_NUL    = 8'd0;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;   // take the input word and update line state
        logic load;     // load the output register
        sel_t sel;
        logic last;
        logic idx_clr;  // restart the command walk
        logic idx_inc;  // advance the command walk
        logic len_clr;  // clear the line
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        act_t act;
        logic prompt_hit;
        logic line_empty;
        logic walk_last;
    } dp_status_t;

endpackage

FILE: rtl/core/tle_dp.sv
// Datapath: parser state, line store, command walk and output register.
module tle_dp #(
    parameter int LINE_BUFFER_SIZE = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tle_pkg::ctrl_cmd_t    cmd,
    output tle_pkg::dp_status_t   status,
    input  logic [7:0]            s_rx_byte,
    output logic [7:0]            m_out_byte,
    output logic [1:0]            m_out_kind,
    output logic                  m_last_of_run
);

    localparam int LEN_W = $clog2(LINE_BUFFER_SIZE);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BUFFER_SIZE - 3);

    logic [7:0]         line_mem [LINE_BUFFER_SIZE];

    tle_pkg::mode_t     mode_reg, mode_next;
    logic               pp_reg;
    logic               prompt_hit_reg;
    tle_pkg::act_t      act_reg, act_next;
    logic [7:0]         rx_reg;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]   rd_addr;
    logic [7:0]         rd_data_reg;
    logic [7:0]         byte_reg, byte_next;
    tle_pkg::kind_t     kind_reg, kind_next;
    logic               last_reg;
    logic               plain;
    logic               printable;

    // Decode the incoming word against current mode
    always_comb begin
        plain     = (mode_reg != tle_pkg::MODE_ESC) && (mode_reg != tle_pkg::MODE_CSI);
        printable = (s_rx_byte >= tle_pkg::CH_SP) && (s_rx_byte < tle_pkg::CH_DEL);
        act_next  = tle_pkg::ACT_NONE;
        mode_next = tle_pkg::MODE_PLAIN;
        if (mode_reg == tle_pkg::MODE_ESC) begin
            mode_next = (s_rx_byte == tle_pkg::CH_LBRK) ? tle_pkg::MODE_CSI
                                                        : tle_pkg::MODE_PLAIN;
        end else if (mode_reg == tle_pkg::MODE_CSI) begin
            mode_next = (s_rx_byte >= tle_pkg::CH_UA && s_rx_byte <= tle_pkg::CH_LZ)
                        ? tle_pkg::MODE_PLAIN : tle_pkg::MODE_CSI;
        end else if (s_rx_byte == tle_pkg::CH_ESC) begin
            mode_next = tle_pkg::MODE_ESC;
        end
        if (plain) begin
            if (s_rx_byte == tle_pkg::CH_CR) begin
                act_next = tle_pkg::ACT_CR;
            end else if (s_rx_byte == tle_pkg::CH_BS) begin
                if (len_reg != '0) begin
                    act_next = tle_pkg::ACT_BS;
                end
            end else if (printable && (len_reg < LEN_MAX)) begin
                act_next = tle_pkg::ACT_CHAR;
            end
        end
    end

    always_comb begin
        len_next = len_reg;
        if (cmd.len_clr) begin
            len_next = '0;
        end else if (cmd.accept && act_next == tle_pkg::ACT_CHAR) begin
            len_next = len_reg + LEN_W'(1);
        end else if (cmd.accept && act_next == tle_pkg::ACT_BS) begin
            len_next = len_reg - LEN_W'(1);
        end
    end

    // Command walk index; read address runs one word ahead of the output
    always_comb begin
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + LEN_W'(1);
        end else begin
            idx_next = idx_reg;
        end
        rd_addr = idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= tle_pkg::MODE_PLAIN;
            pp_reg         <= 1'b1;
            prompt_hit_reg <= 1'b0;
            act_reg        <= tle_pkg::ACT_NONE;
            len_reg        <= '0;
            idx_reg        <= '0;
        end else begin
            if (cmd.accept) begin
                mode_reg       <= mode_next;
                pp_reg         <= 1'b0;
                prompt_hit_reg <= pp_reg;
                act_reg        <= act_next;
            end
            len_reg <= len_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rx_reg <= s_rx_byte;
        end
        if (cmd.accept && act_next == tle_pkg::ACT_CHAR) begin
            line_mem[len_reg] <= s_rx_byte;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    always_comb begin
        kind_next = tle_pkg::KIND_ECHO;
        case (cmd.sel)
            tle_pkg::SEL_PROMPT: byte_next = tle_pkg::CH_PROMPT;
            tle_pkg::SEL_LF:     byte_next = tle_pkg::CH_LF;
            tle_pkg::SEL_CMD: begin
                byte_next = rd_data_reg;
                kind_next = tle_pkg::KIND_CMD;
            end
            tle_pkg::SEL_END: begin
                byte_next = tle_pkg::CH_NUL;
                kind_next = tle_pkg::KIND_END;
            end
            tle_pkg::SEL_BS:     byte_next = tle_pkg::CH_BS;
            tle_pkg::SEL_SP:     byte_next = tle_pkg::CH_SP;
            tle_pkg::SEL_CHAR:   byte_next = rx_reg;
            default:             byte_next = tle_pkg::CH_NUL;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= byte_next;
            kind_reg <= kind_next;
            last_reg <= cmd.last;
        end
    end

    assign status.act        = act_reg;
    assign status.prompt_hit = prompt_hit_reg;
    assign status.line_empty = (len_reg == '0);
    assign status.walk_last  = ({1'b0, idx_reg} + (LEN_W + 1)'(1)) == {1'b0, len_reg};

    assign m_out_byte    = byte_reg;
    assign m_out_kind    = kind_reg;
    assign m_last_of_run = last_reg;

endmodule

FILE: rtl/core/tle_ctrl.sv
// Controller: sequences the result words for each received word.
module tle_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  tle_pkg::dp_status_t status,
    output tle_pkg::ctrl_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_PROMPT   = 4'd2;
    localparam logic [3:0] ST_LF       = 4'd3;
    localparam logic [3:0] ST_CMD      = 4'd4;
    localparam logic [3:0] ST_END      = 4'd5;
    localparam logic [3:0] ST_PROMPT2  = 4'd6;
    localparam logic [3:0] ST_BS1      = 4'd7;
    localparam logic [3:0] ST_SP       = 4'd8;
    localparam logic [3:0] ST_BS2      = 4'd9;
    localparam logic [3:0] ST_CHAR     = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       slot_free;

    function automatic logic [3:0] act_state(input tle_pkg::act_t act);
        logic [3:0] st;
        unique case (act)
            tle_pkg::ACT_CR:   st = ST_LF;
            tle_pkg::ACT_BS:   st = ST_BS1;
            tle_pkg::ACT_CHAR: st = ST_CHAR;
            default:           st = ST_IDLE;
        endcase
        return st;
    endfunction

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = status.prompt_hit ? ST_PROMPT : act_state(status.act);
            end
            ST_PROMPT: begin
                if (slot_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = tle_pkg::SEL_PROMPT;
                    cmd.last   = (status.act == tle_pkg::ACT_NONE);
                    state_next = act_state(status.act);
                end
            end
            ST_LF: begin
                if (slot_free) begin
                    cmd.load    = 1'b1;
                    cmd.sel     = tle_pkg::SEL_LF;
                    cmd.idx_clr = 1'b1;
                    state_next  = status.line_empty ? ST_END : ST_CMD;
                end
            end
            ST_CMD: begin
                if (slot_free) begin
                    cmd.load    = 1'b1;
                    cmd.sel     = tle_pkg::SEL_CMD;
                    cmd.idx_inc = 1'b1;
                    state_next  = status.walk_last ? ST_END : ST_CMD;
                end
            end
            ST_END: begin
                if (slot_free) begin
                    cmd.load    = 1'b1;
                    cmd.sel     = tle_pkg::SEL_END;
                    cmd.len_clr = 1'b1;
                    state_next  = ST_PROMPT2;
                end
            end
            ST_PROMPT2: begin
                if (slot_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = tle_pkg::SEL_PROMPT;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_BS1: begin
                if (slot_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = tle_pkg::SEL_BS;
                    state_next = ST_SP;
                end
            end
            ST_SP: begin
                if (slot_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = tle_pkg::SEL_SP;
                    state_next = ST_BS2;
                end
            end
            ST_BS2: begin
                if (slot_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = tle_pkg::SEL_BS;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CHAR: begin
                if (slot_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = tle_pkg::SEL_CHAR;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Never overwrite a word the receiver has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_valid_reg || m_ready))
        else $error("output word overwritten");

    // An accepted word is always dispatched next
    a_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_DISPATCH))
        else $error("accept not followed by dispatch");

    // The command walk only runs on a carriage return
    a_walk_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMD) |-> (status.act == tle_pkg::ACT_CR))
        else $error("command walk without carriage return");

endmodule

FILE: rtl/core/terminal_line_editor.sv
// Top level of the terminal line editor: controller plus datapath.
//   Input channel (s_valid/s_ready/s_rx_byte) takes one received terminal
//   byte per word. Result channel (m_valid/m_ready/m_out_byte/m_out_kind/
//   m_last_of_run) delivers echo text (kind 0), command bytes (kind 1) and
//   the command end marker (kind 2); m_last_of_run flags the final result
//   word caused by one input word.
//   Timing: one input word is handled at a time. Accept moves the
//   sequencer from idle to dispatch; then each result word is loaded into
//   the output register once the register is free. A printable byte gives
//   its echo, and a carriage return on a line of N stored bytes gives a
//   line feed, the N bytes, the end marker and a prompt; a pending prompt
//   comes first. s_ready returns right after the last result word is
//   loaded, so the next input can be taken while that word still waits.
//   The command walk reads one line store entry per cycle while the
//   receiver keeps up. A word that yields no result goes from dispatch
//   back to idle, which takes the next word. Reset: parse mode goes to
//   plain, the line is cleared and a '>' prompt is queued ahead of the
//   first byte's results. No clearing pass is needed. Stalls: while m_ready
//   is low the result word holds and the sequencer waits; nothing is dropped.
module terminal_line_editor #(
    parameter int LINE_BUFFER_SIZE = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_out_kind,
    output logic       m_last_of_run
);

    tle_pkg::ctrl_cmd_t  cmd;
    tle_pkg::dp_status_t status;

    // Sequencer: decides which word to emit next and when
    tle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Line state, line store and output register
    tle_dp #(
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_rx_byte     (s_rx_byte),
        .m_out_byte    (m_out_byte),
        .m_out_kind    (m_out_kind),
        .m_last_of_run (m_last_of_run)
    );

    // A run still in progress keeps the input closed
    a_run_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_of_run) |-> !s_ready)
        else $error("input open during an unfinished run");

    // End marker carries a zero byte
    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_kind == tle_pkg::KIND_END) |-> (m_out_byte == tle_pkg::CH_NUL))
        else $error("end marker with nonzero byte");

    // A command byte is never the last word of a run
    a_cmd_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_kind == tle_pkg::KIND_CMD) |-> !m_last_of_run)
        else $error("command byte flagged last");

endmodule
